### src/keyframe_table_interpolator_defines.svh
// Assertion macros shared by the keyframe table interpolator RTL.
// Bodies expect clk and rst_n in the scope of the using module.
`ifndef KEYFRAME_TABLE_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define KTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define KTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KTI_ASSERT_IMP(lbl, ante, cons, msg)
`define KTI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/kti_pkg.sv
// Package for the keyframe table interpolator: sizes, codes and shared types.
// Used by the channel interfaces, the arithmetic unit and the top level.
`timescale 1ns / 1ps
package kti_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int NCOMP       = 4;
  localparam int VAL_W       = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COMP_IDX_W  = $clog2(NCOMP);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = 7;
  localparam int KIND_W      = 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Shared multiply/divide unit operand and result sizes.
  localparam int ALU_A_W   = VAL_W + 1 + FRAC_BITS;
  localparam int ALU_B_W   = VAL_W + 1;
  localparam int ALU_P_W   = ALU_A_W + ALU_B_W;
  localparam int ALU_CNT_W = $clog2(ALU_A_W + 1);

  // Products above this bound saturate directly.
  localparam int PROD_LIM_BIT = 62;
  localparam int SUM_W        = PROD_LIM_BIT - FRAC_BITS + 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Value kinds.
  localparam logic [KIND_W-1:0] KIND_HOLD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INT    = 2'd2;

  // Configuration register word index.
  localparam logic [CFG_AW-3:0] CFG_IDX_KIND = '0;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] time_point;
    logic signed [VAL_W-1:0] in_comp0;
    logic signed [VAL_W-1:0] in_comp1;
    logic signed [VAL_W-1:0] in_comp2;
    logic signed [VAL_W-1:0] in_comp3;
  } kti_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_comp0;
    logic signed [VAL_W-1:0] out_comp1;
    logic signed [VAL_W-1:0] out_comp2;
    logic signed [VAL_W-1:0] out_comp3;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      entry_count;
  } kti_out_t;

  // One keyframe as stored in the table memory.
  typedef struct packed {
    logic [NCOMP-1:0][VAL_W-1:0] comp;
    logic [VAL_W-1:0]            tm;
  } kti_entry_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic [ALU_A_W-1:0]  a;
    logic [ALU_B_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ALU_A_W-1:0]  quot;
    logic [ALU_P_W-1:0]  prod;
  } alu_rsp_t;

endpackage

### src/kti_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on kti_pkg for the payload types.
`timescale 1ns / 1ps
interface kti_in_if;
  import kti_pkg::*;
  logic    valid;
  logic    ready;
  kti_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface kti_out_if;
  import kti_pkg::*;
  logic     valid;
  logic     ready;
  kti_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/kti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/kti_alu.sv
// Shared bit-serial unit: unsigned restoring divide and shift-add multiply.
// Depends on kti_pkg for operand sizes and request/response structs.
`timescale 1ns / 1ps
module kti_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  kti_pkg::alu_req_t req,
  output kti_pkg::alu_rsp_t rsp
);
  import kti_pkg::*;

  logic [ALU_A_W-1:0]   sh_r, sh_nxt;
  logic [ALU_P_W-1:0]   acc_r, acc_nxt;
  logic [ALU_B_W-1:0]   b_r, b_nxt;
  logic [ALU_CNT_W-1:0] cnt_r, cnt_nxt;
  alu_op_t              op_r, op_nxt;
  logic                 done_r, done_nxt;
  logic [ALU_B_W:0]     part;
  logic [ALU_B_W+1:0]   diff;

  // One bit of the A operand per cycle, most significant first.
  always_comb begin
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    part     = {acc_r[ALU_B_W-1:0], sh_r[ALU_A_W-1]};
    diff     = {1'b0, part} - {2'b00, b_r};
    if (req.start) begin
      sh_nxt  = req.a;
      acc_nxt = '0;
      b_nxt   = req.b;
      op_nxt  = req.op;
      cnt_nxt = ALU_CNT_W'(ALU_A_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - ALU_CNT_W'(1);
      if (cnt_r == ALU_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
      if (op_r == ALU_DIV) begin
        // Remainder lives in the low bits of the accumulator.
        if (!diff[ALU_B_W+1]) begin
          acc_nxt = ALU_P_W'(diff[ALU_B_W:0]);
          sh_nxt  = {sh_r[ALU_A_W-2:0], 1'b1};
        end else begin
          acc_nxt = ALU_P_W'(part);
          sh_nxt  = {sh_r[ALU_A_W-2:0], 1'b0};
        end
      end else begin
        acc_nxt = {acc_r[ALU_P_W-2:0], 1'b0} + (sh_r[ALU_A_W-1] ? ALU_P_W'(b_r) : '0);
        sh_nxt  = {sh_r[ALU_A_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = sh_r;
  assign rsp.prod = acc_r;

endmodule

### src/keyframe_table_interpolator.sv
// Keyframe table interpolator top level: sequencer, table memory and config port.
// Depends on kti_pkg, kti_if, kti_ram, kti_alu and the assertion macro header.
//
//  Channel | Direction | Handshake              | Contents
//  in_ch   | in        | valid/ready            | op, time_point, in_comp0..3
//  out_ch  | out       | valid/ready            | out_comp0..3, status, entry_count
//  cfg_    | in        | APB write, pready high | value_kind at byte address 0
//
// Clear and unused ops go straight to the output register; an insert scans the table for its
// place, moves the later keys up and writes the new one; a sample scans the keys and, when it
// interpolates, runs one divide and one multiply per component on the bit-serial multiply/divide
// unit. Reset is synchronous, active low, and needs no clearing pass. One request is worked at a
// time; the next one is taken while a finished result waits in the output register.
`timescale 1ns / 1ps
`include "keyframe_table_interpolator_defines.svh"
module keyframe_table_interpolator (
  input  logic                       clk,
  input  logic                       rst_n,
  kti_in_if.sink                     in_ch,
  kti_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [kti_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [kti_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [kti_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import kti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_SH_RD, S_SH_WR, S_INS_WR,
    S_RD_A, S_RD_B, S_LAT_B, S_EVAL, S_DIV_GO, S_DIV_WAIT, S_MUL_GO, S_MUL_WAIT, S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  kti_in_t                     item_r, item_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            jdx_r, jdx_nxt;
  kti_entry_t                  a_r, a_nxt;
  kti_entry_t                  b_r, b_nxt;
  logic [ALU_A_W-1:0]          f_r, f_nxt;
  logic                        fneg_r, fneg_nxt;
  logic [COMP_IDX_W-1:0]       comp_r, comp_nxt;
  logic [NCOMP-1:0][VAL_W-1:0] res_r, res_nxt;
  logic [STATUS_W-1:0]         status_r, status_nxt;
  logic [KIND_W-1:0]           kind_r, kind_nxt;
  logic                        out_valid_r, out_valid_nxt;
  kti_out_t                    out_data_r, out_data_nxt;

  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  kti_entry_t                  ram_wdata, ram_rdata, new_rec;
  alu_req_t                    alu_req;
  alu_rsp_t                    alu_rsp;

  logic [CNT_W-1:0]            idx_m1, jdx_m1;
  logic signed [ALU_B_W-1:0]   n_s, span_s, dv_s;
  logic [ALU_B_W-1:0]          n_abs, dv_abs;
  logic                        lerp_neg;
  logic [PROD_LIM_BIT-FRAC_BITS:0] q_mag;
  logic signed [SUM_W-1:0]     q_s, sum_s;
  logic signed [VAL_W-1:0]     sat_v;
  logic [ALU_B_W-1:0]          t_mag, t_trunc;
  logic [VAL_W-1:0]            lerp_v;
  logic                        cfg_wr;

  kti_ram #(.WIDTH($bits(kti_entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kti_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // Handy derived values.
  assign idx_m1 = idx_r - CNT_W'(1);
  assign jdx_m1 = jdx_r - CNT_W'(1);

  always_comb begin
    new_rec.tm      = item_r.time_point;
    new_rec.comp[0] = item_r.in_comp0;
    new_rec.comp[1] = item_r.in_comp1;
    new_rec.comp[2] = item_r.in_comp2;
    new_rec.comp[3] = item_r.in_comp3;
  end

  // Segment offset and span relative to the earlier key, and the component delta.
  always_comb begin
    n_s    = $signed({item_r.time_point[VAL_W-1], item_r.time_point})
           - $signed({a_r.tm[VAL_W-1], a_r.tm});
    span_s = $signed({b_r.tm[VAL_W-1], b_r.tm}) - $signed({a_r.tm[VAL_W-1], a_r.tm});
    n_abs  = n_s[ALU_B_W-1] ? ALU_B_W'(-n_s) : ALU_B_W'(n_s);
    dv_s   = $signed({b_r.comp[comp_r][VAL_W-1], b_r.comp[comp_r]})
           - $signed({a_r.comp[comp_r][VAL_W-1], a_r.comp[comp_r]});
    dv_abs = dv_s[ALU_B_W-1] ? ALU_B_W'(-dv_s) : ALU_B_W'(dv_s);
  end

  // Scale the product back, add the earlier key, saturate and optionally truncate.
  always_comb begin
    lerp_neg = dv_s[ALU_B_W-1] ^ fneg_r;
    q_mag    = alu_rsp.prod[PROD_LIM_BIT:FRAC_BITS];
    q_s      = lerp_neg ? -$signed(SUM_W'(q_mag)) : $signed(SUM_W'(q_mag));
    sum_s    = $signed(SUM_W'($signed(a_r.comp[comp_r]))) + q_s;
    if (alu_rsp.prod > (ALU_P_W'(1) << PROD_LIM_BIT)) begin
      sat_v = lerp_neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum_s > $signed(SUM_W'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      sat_v = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum_s < -$signed(SUM_W'({1'b1, {(VAL_W-1){1'b0}}}))) begin
      sat_v = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_v = sum_s[VAL_W-1:0];
    end
    t_mag   = sat_v[VAL_W-1] ? ALU_B_W'(-$signed({sat_v[VAL_W-1], sat_v}))
                             : ALU_B_W'({1'b0, sat_v});
    t_trunc = t_mag & ~ALU_B_W'((1 << FRAC_BITS) - 1);
    if (kind_r == KIND_INT) begin
      lerp_v = sat_v[VAL_W-1] ? VAL_W'(-t_trunc) : t_trunc[VAL_W-1:0];
    end else begin
      lerp_v = sat_v;
    end
  end

  // Configuration write decode.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == CFG_IDX_KIND) ? CFG_DW'(kind_r) : '0;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    jdx_nxt       = jdx_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    f_nxt         = f_r;
    fneg_nxt      = fneg_r;
    comp_nxt      = comp_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[ADDR_W-1:0];
    ram_wdata     = new_rec;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[ADDR_W-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = f_r;
    alu_req.b     = dv_abs;

    if (cfg_wr && cfg_paddr[CFG_AW-1:2] == CFG_IDX_KIND) begin
      kind_nxt = cfg_pwdata[KIND_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt   = in_ch.payload;
          res_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          case (in_ch.payload.op)
            OP_CLEAR: count_nxt = '0;
            OP_INSERT: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            OP_SAMPLE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = CNT_W'(1);
                state_nxt = S_SCAN_RD;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      // Find the first key later than the request time.
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_SCAN_END;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if ($signed(item_r.time_point) < $signed(ram_rdata.tm)) begin
          state_nxt = S_SCAN_END;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (item_r.op == OP_INSERT) begin
          jdx_nxt   = count_r;
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_RD_A;
        end
      end
      // Open a slot by moving later keys up one place, top first.
      S_SH_RD: begin
        if (jdx_r == idx_r) begin
          state_nxt = S_INS_WR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = jdx_m1[ADDR_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = jdx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        jdx_nxt   = jdx_m1;
        state_nxt = S_SH_RD;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      // Fetch the keys around the sample time.
      S_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = idx_m1[ADDR_W-1:0];
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        a_nxt     = ram_rdata;
        ram_re    = 1'b1;
        state_nxt = S_LAT_B;
      end
      S_LAT_B: begin
        b_nxt     = ram_rdata;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (idx_r == count_r || kind_r == KIND_HOLD || a_r.tm == b_r.tm) begin
          res_nxt   = a_r.comp;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV_GO;
        end
      end
      // Fraction of the way through the segment.
      S_DIV_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = {n_abs, {FRAC_BITS{1'b0}}};
        alu_req.b     = ALU_B_W'(span_s);
        fneg_nxt      = n_s[ALU_B_W-1];
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (alu_rsp.done) begin
          f_nxt     = alu_rsp.quot;
          comp_nxt  = '0;
          state_nxt = S_MUL_GO;
        end
      end
      // Scale each component delta by the fraction.
      S_MUL_GO: begin
        alu_req.start = 1'b1;
        state_nxt     = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (alu_rsp.done) begin
          res_nxt[comp_r] = lerp_v;
          if (comp_r == COMP_IDX_W'(NCOMP - 1)) begin
            state_nxt = S_OUT;
          end else begin
            comp_nxt  = comp_r + COMP_IDX_W'(1);
            state_nxt = S_MUL_GO;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_comp0   = res_r[0];
          out_data_nxt.out_comp1   = res_r[1];
          out_data_nxt.out_comp2   = res_r[2];
          out_data_nxt.out_comp3   = res_r[3];
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = ENTRY_W'(count_r);
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      kind_r      <= KIND_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    jdx_r      <= jdx_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    f_r        <= f_nxt;
    fneg_r     <= fneg_nxt;
    comp_r     <= comp_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks on the sequencer.
  `KTI_ASSERT_IMP(a_full_refusal, (state_r == S_OUT && status_r == ST_FULL), (count_r == CNT_W'(TABLE_DEPTH)), "insert refused while the table has room")
  `KTI_ASSERT_NXT(a_insert_count, (state_r == S_INS_WR), (count_r == $past(count_r) + CNT_W'(1)), "insert did not grow the key count by one")
  `KTI_ASSERT_IMP(a_alu_idle, (in_ch.ready), (!alu_rsp.busy), "request taken while the arithmetic unit is busy")

endmodule

### bench/testbench.sv
// Self-checking bench for the keyframe table interpolator: valid/ready request
// and result channels, value_kind writes over the APB port. Needs kti_pkg, kti_if.
`timescale 1ns / 1ps
module testbench;
  import kti_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  int mismatches;

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Scoreboard: keyframe table mirror and queue of expected samples.
  class keyframe_scoreboard;
    logic signed [31:0] key_tm [TABLE_DEPTH];
    logic signed [31:0] key_val [NCOMP][TABLE_DEPTH];
    int unsigned count;
    logic [KIND_W-1:0] kind;
    kti_out_t pending [$];
    int errors;
    int checked;

    function void clear_state();
      count = 0;
      kind = KIND_HOLD;
    endfunction

    function longint lerp_one(longint v1, longint v2, longint f);
      longint dv, adv, af, s;
      dv = v2 - v1;
      adv = dv < 0 ? -dv : dv;
      af = f < 0 ? -f : f;
      if (adv == 0 || af == 0) return v1;
      if (af > (64'sd1 <<< 62) / adv)
        return ((dv < 0) != (f < 0)) ? -64'sd2147483648 : 64'sd2147483647;
      s = v1 + (dv * f) / (64'sd1 <<< FRAC_BITS);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(kti_in_t rq);
      kti_out_t r;
      logic signed [31:0] vin [NCOMP];
      longint res [NCOMP];
      longint span, f;
      int unsigned pos, idx;
      vin[0] = rq.in_comp0; vin[1] = rq.in_comp1;
      vin[2] = rq.in_comp2; vin[3] = rq.in_comp3;
      for (int c = 0; c < NCOMP; c++) res[c] = 0;
      r = '0;
      r.status = ST_OK;
      if (rq.op == OP_CLEAR) begin
        count = 0;
      end else if (rq.op == OP_INSERT) begin
        if (count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = count;
          if (count > 0 && rq.time_point < key_tm[count-1]) begin
            for (int i = 0; i < count; i++)
              if (rq.time_point < key_tm[i]) begin
                pos = i;
                break;
              end
          end
          for (int i = count; i > pos; i--) begin
            key_tm[i] = key_tm[i-1];
            for (int c = 0; c < NCOMP; c++) key_val[c][i] = key_val[c][i-1];
          end
          key_tm[pos] = rq.time_point;
          for (int c = 0; c < NCOMP; c++) key_val[c][pos] = vin[c];
          count++;
        end
      end else if (rq.op == OP_SAMPLE) begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = 1;
          while (idx < count && !(rq.time_point < key_tm[idx])) idx++;
          if (idx >= count || kind == KIND_HOLD || key_tm[idx] == key_tm[idx-1]) begin
            for (int c = 0; c < NCOMP; c++) res[c] = key_val[c][idx-1];
          end else begin
            span = longint'(key_tm[idx]) - longint'(key_tm[idx-1]);
            f = ((longint'(rq.time_point) - longint'(key_tm[idx-1])) *
                 (64'sd1 <<< FRAC_BITS)) / span;
            for (int c = 0; c < NCOMP; c++) begin
              res[c] = lerp_one(key_val[c][idx-1], key_val[c][idx], f);
              if (kind == KIND_INT)
                res[c] = (res[c] / (64'sd1 <<< FRAC_BITS)) * (64'sd1 <<< FRAC_BITS);
            end
          end
        end
      end
      r.out_comp0 = res[0][31:0]; r.out_comp1 = res[1][31:0];
      r.out_comp2 = res[2][31:0]; r.out_comp3 = res[3][31:0];
      r.entry_count = count[ENTRY_W-1:0];
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation.
    task check_result(kti_out_t got);
      kti_out_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.out_comp0 !== e.out_comp0) report_mismatch("comp0", got.out_comp0, e.out_comp0);
      if (got.out_comp1 !== e.out_comp1) report_mismatch("comp1", got.out_comp1, e.out_comp1);
      if (got.out_comp2 !== e.out_comp2) report_mismatch("comp2", got.out_comp2, e.out_comp2);
      if (got.out_comp3 !== e.out_comp3) report_mismatch("comp3", got.out_comp3, e.out_comp3);
      if (got.status !== e.status) report_mismatch("status", got.status, e.status);
      if (got.entry_count !== e.entry_count)
        report_mismatch("entry_count", got.entry_count, e.entry_count);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  kti_in_if in_ch ();
  kti_out_if out_ch ();

  keyframe_table_interpolator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  keyframe_scoreboard sb;
  int idle_cycles;
  bit quiet;
  int sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, check at each accepting edge.
  initial begin
    int burst;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_ch.ready <= 0;
        repeat (burst) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout waiting on the block");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic signed [31:0] tp,
                              logic signed [31:0] c0, logic signed [31:0] c1,
                              logic signed [31:0] c2, logic signed [31:0] c3);
    kti_in_t rq;
    int burst;
    rq.op = op; rq.time_point = tp;
    rq.in_comp0 = c0; rq.in_comp1 = c1; rq.in_comp2 = c2; rq.in_comp3 = c3;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 13);
      in_ch.valid <= 0;
      repeat (burst) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.payload <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(rq);
    sent++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // Wait until every expected result has arrived, plus drain time.
  task automatic wait_drained();
    drop_valid();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_kind(logic [CFG_DW-1:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= CFG_AW'(CFG_IDX_KIND) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
    sb.kind = v[KIND_W-1:0];
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 200000)) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // A burst: clear, a handful of keys, then six samples with an occasional unused op among them.
  task automatic random_phase(int nreq);
    int nkeys;
    logic signed [31:0] base, tp;
    while (nreq > 0) begin
      send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      nkeys = $urandom_range(1, 6);
      base = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2000)) - 1000;
      for (int k = 0; k < nkeys; k++) begin
        tp = ($urandom_range(0, 3) == 0) ? $urandom :
             base + $signed($urandom_range(0, 1 << 20)) - (1 << 18);
        send_request(OP_INSERT, tp, rand_val(), rand_val(), rand_val(), rand_val());
      end
      for (int k = 0; k < 6; k++) begin
        tp = ($urandom_range(0, 4) == 0) ? $urandom :
             base + $signed($urandom_range(0, 3 << 19)) - (1 << 19);
        send_request(($urandom_range(0, 9) == 0) ? OP_W'(3) : OP_SAMPLE,
                     tp, $urandom, $urandom, $urandom, $urandom);
      end
      nreq -= nkeys + 7;
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.payload = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    quiet = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty sample, extremes, equal times, out-of-order insert.
    send_request(OP_SAMPLE, 0, 0, 0, 0, 0);
    send_request(OP_INSERT, 32'sh00010000, 32'sh7fffffff, 32'sh80000000, 0, -5);
    send_request(OP_SAMPLE, 32'sh80000000, 0, 0, 0, 0);
    send_request(OP_INSERT, 32'sh00030000, 32'sh80000000, 32'sh7fffffff, 32'sh00050000, 7);
    send_request(OP_INSERT, 32'sh00030000, 1, 2, 3, 4);
    send_request(OP_INSERT, 32'sh80000000, 32'shffffffff, 0, 32'sh00018000, 9);
    send_request(OP_INSERT, 32'sh7fffffff, 0, 0, 0, 0);
    send_request(OP_SAMPLE, 32'sh00020000, 0, 0, 0, 0);
    send_request(OP_SAMPLE, 32'sh7fffffff, 0, 0, 0, 0);
    send_request(OP_W'(3), 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    wait_drained();
    for (int kv = 1; kv < 4; kv++) begin
      write_kind(kv);
      send_request(OP_SAMPLE, 32'sh00020000, 0, 0, 0, 0);
      send_request(OP_SAMPLE, 32'sh00000000, 0, 0, 0, 0);
      send_request(OP_SAMPLE, 32'sh80000000, 0, 0, 0, 0);
      send_request(OP_SAMPLE, 32'sh00030000, 0, 0, 0, 0);
      wait_drained();
    end

    // Fill the table past its depth, then sample it and clear.
    write_kind(KIND_LINEAR);
    for (int k = 0; k < TABLE_DEPTH + 2; k++)
      send_request(OP_INSERT, $urandom, rand_val(), rand_val(), rand_val(), rand_val());
    for (int k = 0; k < 8; k++) send_request(OP_SAMPLE, $urandom, 0, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases over every value kind, the last one with no random stalls.
    write_kind(KIND_HOLD);
    random_phase(120);
    wait_drained();
    write_kind(KIND_INT);
    random_phase(150);
    wait_drained();
    write_kind(KIND_LINEAR);
    random_phase(150);
    wait_drained();
    quiet = 1;
    write_kind(KIND_INT);
    random_phase(100);
    wait_drained();

    $display("covered %0d requests over all value kinds, full table and empty samples",
             sent);
    $display("%0d results checked, %0d mismatches", sb.checked, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

### keyframe_table_interpolator.f
+incdir+src
src/kti_pkg.sv
src/kti_if.sv
src/kti_ram.sv
src/kti_alu.sv
src/keyframe_table_interpolator.sv
bench/testbench.sv
